>>> design/i2c_rts_pkg.sv
// Package for the I2C register transaction sequencer.
// Holds the transaction structs, the sequencer state types and the command and action codes.
// It depends on nothing else.
package i2c_rts_pkg;

    localparam int unsigned ADDR_W  = 7;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CMD_W   = 3;
    localparam int unsigned ACT_W   = 3;
    localparam int unsigned STAT_W  = 2;

    localparam logic READ_BIT = 1'b1;

    localparam logic [CMD_W-1:0] CMD_START_REG_WRITE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START_REG_READ  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_START_READ      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WRITE_DONE      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ_DONE       = 3'd4;

    localparam logic [ACT_W-1:0] ACT_NONE      = 3'd0;
    localparam logic [ACT_W-1:0] ACT_START_W   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_START_R   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SEND      = 3'd3;
    localparam logic [ACT_W-1:0] ACT_ACK       = 3'd4;
    localparam logic [ACT_W-1:0] ACT_NACK_STOP = 3'd5;
    localparam logic [ACT_W-1:0] ACT_STOP      = 3'd6;

    localparam logic [STAT_W-1:0] ST_PENDING = 2'd0;
    localparam logic [STAT_W-1:0] ST_OK      = 2'd1;
    localparam logic [STAT_W-1:0] ST_FAILED  = 2'd2;

    typedef enum logic [1:0] {
        KIND_IDLE      = 2'd0,
        KIND_WRITE_REG = 2'd1,
        KIND_READ_REG  = 2'd2,
        KIND_READ      = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PH_REGISTER = 2'd0,
        PH_RESTART  = 2'd1,
        PH_DATA     = 2'd2
    } phase_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] device_address;
        logic [BYTE_W-1:0] register_address;
        logic [BYTE_W-1:0] byte_count;
        logic [BYTE_W-1:0] tx_byte;
        logic [BYTE_W-1:0] rx_byte;
        logic              arbitration_lost;
        logic              bus_error;
    } cmd_item_t;

    typedef struct packed {
        logic [ACT_W-1:0]  bus_action;
        logic [BYTE_W-1:0] bus_byte;
        logic [BYTE_W-1:0] read_byte;
        logic              read_valid;
        logic [STAT_W-1:0] status;
        logic              done_res;
    } res_item_t;

    typedef struct packed {
        kind_t             kind;
        phase_t            phase;
        logic [ADDR_W-1:0] target_address;
        logic [BYTE_W-1:0] register_byte;
        logic [BYTE_W-1:0] bytes_left;
        logic [STAT_W-1:0] result_status;
    } seq_state_t;

endpackage

>>> design/i2c_register_transaction_sequencer.sv
// Top level of the I2C register transaction sequencer: input register, state and result register.
// Depends on i2c_rts_pkg and i2c_rts_step.
// An accepted transaction waits in the input register and moves to res when res is free.
// Throughput: one transaction per cycle, limited only by res_stall.
// Reset clears the valid flags and the sequencer state to idle with pending status.
module i2c_register_transaction_sequencer (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    output logic                    cmd_stall,
    input  i2c_rts_pkg::cmd_item_t  cmd,
    output logic                    res_valid,
    input  logic                    res_stall,
    output i2c_rts_pkg::res_item_t  res
);
    import i2c_rts_pkg::*;

    logic       in_valid_reg;
    cmd_item_t  in_item_reg;
    seq_state_t state_reg;
    seq_state_t state_next;
    res_item_t  step_result;
    logic       out_valid_reg;
    res_item_t  out_item_reg;
    logic       advance;
    logic       in_take;

    assign advance   = in_valid_reg && (!out_valid_reg || !res_stall);
    assign cmd_stall = in_valid_reg && !advance;
    assign in_take   = cmd_valid && !cmd_stall;

    i2c_rts_step u_step (
        .item       (in_item_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!cmd_stall)
        begin
            in_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.kind           <= KIND_IDLE;
            state_reg.phase          <= PH_REGISTER;
            state_reg.target_address <= '0;
            state_reg.register_byte  <= '0;
            state_reg.bytes_left     <= '0;
            state_reg.result_status  <= ST_PENDING;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !res_stall)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= step_result;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_item_reg;

endmodule

>>> design/i2c_rts_step.sv
// Next-state and result logic of the sequencer for one transaction.
// Purely combinational; uses the types and codes of i2c_rts_pkg.
module i2c_rts_step (
    input  i2c_rts_pkg::cmd_item_t  item,
    input  i2c_rts_pkg::seq_state_t state,
    output i2c_rts_pkg::seq_state_t state_next,
    output i2c_rts_pkg::res_item_t  result
);
    import i2c_rts_pkg::*;

    typedef enum logic [3:0] {
        OUT_IGNORE,
        OUT_ABORT,
        OUT_START_REG,
        OUT_START_READ,
        OUT_SEND_REG,
        OUT_RESTART,
        OUT_SEND_DATA,
        OUT_WRITE_END,
        OUT_READ_EMPTY,
        OUT_READ_ACK,
        OUT_READ_LAST
    } outcome_t;

    outcome_t          outcome;
    logic              err;
    logic [BYTE_W-1:0] bytes_dec;

    assign err       = item.arbitration_lost | item.bus_error;
    assign bytes_dec = state.bytes_left - BYTE_W'(1);

    always_comb
    begin
        outcome = OUT_IGNORE;
        unique case (item.command)
            CMD_START_REG_WRITE, CMD_START_REG_READ:
            begin
                outcome = (state.kind != KIND_IDLE) ? OUT_ABORT : OUT_START_REG;
            end
            CMD_START_READ:
            begin
                outcome = (state.kind != KIND_IDLE) ? OUT_ABORT : OUT_START_READ;
            end
            CMD_WRITE_DONE:
            begin
                priority if (err || (state.kind != KIND_WRITE_REG &&
                                     state.kind != KIND_READ_REG))
                    outcome = OUT_ABORT;
                else if (state.phase == PH_REGISTER)
                    outcome = OUT_SEND_REG;
                else if (state.kind == KIND_READ_REG && state.phase == PH_RESTART)
                    outcome = OUT_RESTART;
                else if (state.kind == KIND_WRITE_REG && state.phase == PH_DATA)
                    outcome = (state.bytes_left != '0) ? OUT_SEND_DATA : OUT_WRITE_END;
                else
                    outcome = OUT_ABORT;
            end
            CMD_READ_DONE:
            begin
                priority if (err || state.kind != KIND_READ || state.phase != PH_DATA)
                    outcome = OUT_ABORT;
                else if (state.bytes_left == '0)
                    outcome = OUT_READ_EMPTY;
                else if (bytes_dec != '0)
                    outcome = OUT_READ_ACK;
                else
                    outcome = OUT_READ_LAST;
            end
            default:
            begin
                outcome = OUT_IGNORE;
            end
        endcase
    end

    always_comb
    begin
        state_next = state;
        unique case (outcome)
            OUT_IGNORE:
            begin
                state_next = state;
            end
            OUT_ABORT:
            begin
                state_next.kind          = KIND_IDLE;
                state_next.phase         = PH_REGISTER;
                state_next.result_status = ST_FAILED;
            end
            OUT_START_REG:
            begin
                state_next.kind           = (item.command == CMD_START_REG_WRITE) ?
                                            KIND_WRITE_REG : KIND_READ_REG;
                state_next.phase          = PH_REGISTER;
                state_next.target_address = item.device_address;
                state_next.register_byte  = item.register_address;
                state_next.bytes_left     = item.byte_count;
                state_next.result_status  = ST_PENDING;
            end
            OUT_START_READ:
            begin
                state_next.kind           = KIND_READ;
                state_next.phase          = PH_DATA;
                state_next.target_address = item.device_address;
                state_next.register_byte  = '0;
                state_next.bytes_left     = item.byte_count;
                state_next.result_status  = ST_PENDING;
            end
            OUT_SEND_REG:
            begin
                state_next.phase = (state.kind == KIND_WRITE_REG) ? PH_DATA : PH_RESTART;
            end
            OUT_RESTART:
            begin
                state_next.kind  = KIND_READ;
                state_next.phase = PH_DATA;
            end
            OUT_SEND_DATA, OUT_READ_ACK:
            begin
                state_next.bytes_left = bytes_dec;
            end
            OUT_WRITE_END, OUT_READ_EMPTY:
            begin
                state_next.kind          = KIND_IDLE;
                state_next.phase         = PH_REGISTER;
                state_next.result_status = ST_OK;
            end
            OUT_READ_LAST:
            begin
                state_next.kind          = KIND_IDLE;
                state_next.phase         = PH_REGISTER;
                state_next.bytes_left    = bytes_dec;
                state_next.result_status = ST_OK;
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

    always_comb
    begin
        result            = '0;
        result.bus_action = ACT_NONE;
        result.status     = ST_PENDING;
        unique case (outcome)
            OUT_IGNORE:
            begin
                result.status = state.result_status;
            end
            OUT_ABORT:
            begin
                result.bus_action = ACT_STOP;
                result.status     = ST_FAILED;
                result.done_res   = 1'b1;
            end
            OUT_START_REG:
            begin
                result.bus_action = ACT_START_W;
                result.bus_byte   = {item.device_address, 1'b0};
            end
            OUT_START_READ:
            begin
                result.bus_action = ACT_START_R;
                result.bus_byte   = {item.device_address, READ_BIT};
            end
            OUT_SEND_REG:
            begin
                result.bus_action = ACT_SEND;
                result.bus_byte   = state.register_byte;
            end
            OUT_RESTART:
            begin
                result.bus_action = ACT_START_R;
                result.bus_byte   = {state.target_address, READ_BIT};
            end
            OUT_SEND_DATA:
            begin
                result.bus_action = ACT_SEND;
                result.bus_byte   = item.tx_byte;
            end
            OUT_WRITE_END:
            begin
                result.bus_action = ACT_STOP;
                result.status     = ST_OK;
                result.done_res   = 1'b1;
            end
            OUT_READ_EMPTY:
            begin
                result.bus_action = ACT_NACK_STOP;
                result.status     = ST_OK;
                result.done_res   = 1'b1;
            end
            OUT_READ_ACK:
            begin
                result.bus_action = ACT_ACK;
                result.read_byte  = item.rx_byte;
                result.read_valid = 1'b1;
            end
            OUT_READ_LAST:
            begin
                result.bus_action = ACT_NACK_STOP;
                result.read_byte  = item.rx_byte;
                result.read_valid = 1'b1;
                result.status     = ST_OK;
                result.done_res   = 1'b1;
            end
            default:
            begin
                result.status = state.result_status;
            end
        endcase
    end

endmodule

>>> design/i2c_rts_checker.sv
// Port-level checker for the I2C register transaction sequencer, bound to the top level.
// Depends on i2c_rts_pkg and i2c_register_transaction_sequencer.
module i2c_rts_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   cmd_valid,
    input logic                   cmd_stall,
    input i2c_rts_pkg::cmd_item_t cmd,
    input logic                   res_valid,
    input logic                   res_stall,
    input i2c_rts_pkg::res_item_t res
);
    import i2c_rts_pkg::*;

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> (res_valid && res_stall))
    else $error("Transaction stalled while the result side could move.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.done_res) |-> (res.status == ST_OK || res.status == ST_FAILED))
    else $error("Ending transaction carries pending status.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.read_valid) |->
            (res.bus_action == ACT_ACK || res.bus_action == ACT_NACK_STOP))
    else $error("Received byte returned without a receive action.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> (res_valid && $stable(res)))
    else $error("Stalled result changed or vanished.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_stall) |=> (cmd_valid && $stable(cmd)))
    else $error("Stalled command changed or vanished.");

endmodule

bind i2c_register_transaction_sequencer i2c_rts_checker u_i2c_rts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);
